>>> sv/mtq_pkg.sv
// mtq_pkg: shared constants, beat types, register indexes and sequencer states
// for the magnetorquer play-hysteresis core. No dependencies.
package mtq_pkg;

    localparam int AXES        = 3;
    localparam int DIPOLE_BITS = 24;

    localparam int LIM_W      = 23;
    localparam int SCALE_W    = 16;
    localparam int COEFF_W    = 32;
    localparam int POWER_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Q1.15 gain, one plus the scale error, always fits 17 bits unsigned
    localparam int FRAC_BITS  = 15;
    localparam int GAIN_W     = FRAC_BITS + 2;
    localparam int GAIN_ONE   = 1 << FRAC_BITS;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

    // scaled value and play window widths
    localparam int Q_W   = DIPOLE_BITS + 2;
    localparam int BND_W = ((Q_W > LIM_W + 1) ? Q_W : LIM_W + 1) + 1;
    localparam int MUL_W = (BND_W > COEFF_W + 1) ? BND_W : COEFF_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SUM_W  = ((2 * DIPOLE_BITS + 2) > COEFF_W + 1) ?
                            (2 * DIPOLE_BITS + 2) : COEFF_W + 1;
    localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;

    localparam longint DIP_MAX = (longint'(1) <<< (DIPOLE_BITS - 1)) - 1;
    localparam longint DIP_MIN = -DIP_MAX - 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_DIPOLE    = 3'd0,
        REG_RESIDUAL      = 3'd1,
        REG_SCALE_ERROR   = 3'd2,
        REG_POWER_COEFF   = 3'd3,
        REG_FAULT_STUCK   = 3'd4,
        REG_FAULT_DROPOUT = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_BOUND,
        ST_PLAY,
        ST_STORE,
        ST_SQUARE,
        ST_ACCUM,
        ST_POWER,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic                          action;
        logic signed [DIPOLE_BITS-1:0] cmd_x;
        logic signed [DIPOLE_BITS-1:0] cmd_y;
        logic signed [DIPOLE_BITS-1:0] cmd_z;
    } cmd_item_t;

    typedef struct packed {
        logic signed [DIPOLE_BITS-1:0] dipole_x;
        logic signed [DIPOLE_BITS-1:0] dipole_y;
        logic signed [DIPOLE_BITS-1:0] dipole_z;
        logic        [POWER_W-1:0]     bus_power;
    } res_item_t;

endpackage

>>> sv/magnetorquer_play_hysteresis_core.sv
// magnetorquer_play_hysteresis_core: per-axis clamp, gain, play operator and bus power
// under a small sequencer, with the gain, the squares and the power product run through
// one shared signed multiplier; uses mtq_pkg. Each command beat steps through scale,
// bound, play and store for every axis, then square and accumulate for every axis, then
// power and finish; the stuck fault skips the play update. No new beat is taken until the
// sequencer is back in idle. Reset clears the control, configuration and play registers.
module magnetorquer_play_hysteresis_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  mtq_pkg::cmd_item_t            cmd_item,
    output logic                          res_valid,
    input  logic                          res_stall,
    output mtq_pkg::res_item_t            res_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mtq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mtq_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mtq_pkg::*;

    localparam logic signed [BND_W-1:0] SAT_HI = BND_W'(DIP_MAX);
    localparam logic signed [BND_W-1:0] SAT_LO = BND_W'(DIP_MIN);

    // configuration
    logic        [LIM_W-1:0]   max_dipole_reg;
    logic        [LIM_W-1:0]   residual_reg;
    logic signed [SCALE_W-1:0] scale_error_reg;
    logic        [COEFF_W-1:0] power_coeff_reg;
    logic                      fault_stuck_reg;
    logic                      fault_dropout_reg;

    // sequencer
    seq_state_t        state_reg, state_next;
    logic [AXIS_W-1:0] axis_reg, axis_next;
    logic              last_axis;

    // per-axis state and working registers
    logic signed [DIPOLE_BITS-1:0] cmd_reg  [AXES];
    logic signed [DIPOLE_BITS-1:0] pos_reg  [AXES];
    logic signed [DIPOLE_BITS-1:0] held_reg [AXES];
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [BND_W-1:0]       lo_reg, hi_reg, box_reg;
    logic        [SUM_W-1:0]       sum_reg, sum_next;
    logic                          res_valid_reg, res_valid_next;
    res_item_t                     res_item_reg, res_item_next;

    logic                          accept, load_res, zero_cmd;
    logic signed [DIPOLE_BITS-1:0] all_cmd  [3];
    logic signed [DIPOLE_BITS-1:0] held_pad [3];

    logic signed [BND_W-1:0]       lim_w, res_w, x_w, x_clamp;
    logic signed [BND_W-1:0]       q_w, lo_next, hi_next, pos_w, box_next;
    logic signed [BND_W-1:0]       sat_w, lim_sat;
    logic signed [PROD_W-1:0]      rounded;
    logic signed [Q_W-1:0]         q_val;
    logic        [GAIN_W-1:0]      gain;
    logic signed [DIPOLE_BITS:0]   held_w, held_mag;
    logic signed [MUL_W-1:0]       mul_a, mul_b;
    logic signed [DIPOLE_BITS-1:0] pos_new, held_new;
    logic        [POWER_W-1:0]     power_val;
    logic                          power_sat;

    assign cfg_ready = 1'b1;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign zero_cmd  = cmd_item.action || fault_dropout_reg;
    assign last_axis = (axis_reg == AXIS_W'(AXES - 1));
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    always_comb
    begin
        all_cmd[0] = cmd_item.cmd_x;
        all_cmd[1] = cmd_item.cmd_y;
        all_cmd[2] = cmd_item.cmd_z;
        for (int i = 0; i < 3; i++)
        begin
            held_pad[i] = '0;
        end
        for (int i = 0; i < AXES; i++)
        begin
            held_pad[i] = held_reg[i];
        end
    end

    // datapath around the shared multiplier
    always_comb
    begin
        lim_w = signed'({{(BND_W - LIM_W){1'b0}}, max_dipole_reg});
        res_w = signed'({{(BND_W - LIM_W){1'b0}}, residual_reg});

        // input clamp to +/- max dipole
        x_w = BND_W'(cmd_reg[axis_reg]);
        if (max_dipole_reg != '0 && x_w < -lim_w)
            x_clamp = -lim_w;
        else if (max_dipole_reg != '0 && x_w > lim_w)
            x_clamp = lim_w;
        else
            x_clamp = x_w;
        gain = GAIN_W'(GAIN_ONE) + GAIN_W'(unsigned'(GAIN_W'(scale_error_reg)));

        // round half up, then the play window around the scaled value
        rounded = prod_reg + PROD_W'(ROUND_HALF);
        q_val   = rounded[FRAC_BITS +: Q_W];
        q_w     = BND_W'(q_val);
        lo_next = q_w - res_w;
        hi_next = q_w + res_w;

        pos_w = BND_W'(pos_reg[axis_reg]);
        if (pos_w < lo_reg)
            box_next = lo_reg;
        else if (pos_w > hi_reg)
            box_next = hi_reg;
        else
            box_next = pos_w;

        if (box_reg > SAT_HI)
            sat_w = SAT_HI;
        else if (box_reg < SAT_LO)
            sat_w = SAT_LO;
        else
            sat_w = box_reg;
        if (max_dipole_reg != '0 && sat_w < -lim_w)
            lim_sat = -lim_w;
        else if (max_dipole_reg != '0 && sat_w > lim_w)
            lim_sat = lim_w;
        else
            lim_sat = sat_w;
        pos_new  = sat_w[DIPOLE_BITS-1:0];
        held_new = lim_sat[DIPOLE_BITS-1:0];

        held_w   = (DIPOLE_BITS + 1)'(held_reg[axis_reg]);
        held_mag = held_w[DIPOLE_BITS] ? -held_w : held_w;

        unique case (state_reg)
            ST_SQUARE:
            begin
                mul_a = signed'({{(MUL_W - DIPOLE_BITS){1'b0}}, held_mag[DIPOLE_BITS-1:0]});
                mul_b = mul_a;
            end
            // the power product must stay put while the result waits
            ST_POWER, ST_FINISH:
            begin
                mul_a = signed'({{(MUL_W - COEFF_W){1'b0}}, sum_reg[COEFF_W-1:0]});
                mul_b = signed'({{(MUL_W - COEFF_W){1'b0}}, power_coeff_reg});
            end
            default:
            begin
                mul_a = MUL_W'(x_clamp);
                mul_b = signed'({{(MUL_W - GAIN_W){1'b0}}, gain});
            end
        endcase

        power_sat = (sum_reg[SUM_W-1:COEFF_W] != '0) ||
                    (prod_reg[2*COEFF_W-1:COEFF_W] != '0);
        if (max_dipole_reg == '0 || power_coeff_reg == '0 || sum_reg == '0)
            power_val = '0;
        else if (power_sat)
            power_val = '1;
        else
            power_val = prod_reg[POWER_W-1:0];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        sum_next       = sum_reg;
        load_res       = 1'b0;
        res_item_next  = res_item_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    axis_next  = '0;
                    sum_next   = '0;
                    state_next = fault_stuck_reg ? ST_SQUARE : ST_SCALE;
                end
            end
            ST_SCALE:  state_next = ST_BOUND;
            ST_BOUND:  state_next = ST_PLAY;
            ST_PLAY:   state_next = ST_STORE;
            ST_STORE:
            begin
                axis_next  = last_axis ? '0 : AXIS_W'(axis_reg + 1'b1);
                state_next = last_axis ? ST_SQUARE : ST_SCALE;
            end
            ST_SQUARE: state_next = ST_ACCUM;
            ST_ACCUM:
            begin
                sum_next   = sum_reg + prod_reg[SUM_W-1:0];
                axis_next  = last_axis ? '0 : AXIS_W'(axis_reg + 1'b1);
                state_next = last_axis ? ST_POWER : ST_SQUARE;
            end
            ST_POWER:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                // wait while the previous result still sits in the output register
                if (!res_valid_reg || !res_stall)
                begin
                    load_res                = 1'b1;
                    res_item_next.dipole_x  = held_pad[0];
                    res_item_next.dipole_y  = held_pad[1];
                    res_item_next.dipole_z  = held_pad[2];
                    res_item_next.bus_power = power_val;
                    state_next              = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase

        res_valid_next = (res_valid_reg && res_stall) || load_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            axis_reg          <= '0;
            res_valid_reg     <= 1'b0;
            max_dipole_reg    <= '0;
            residual_reg      <= '0;
            scale_error_reg   <= '0;
            power_coeff_reg   <= '0;
            fault_stuck_reg   <= 1'b0;
            fault_dropout_reg <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                pos_reg[i]  <= '0;
                held_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            res_valid_reg <= res_valid_next;
            if (state_reg == ST_STORE)
            begin
                pos_reg[axis_reg]  <= pos_new;
                held_reg[axis_reg] <= held_new;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_MAX_DIPOLE:    max_dipole_reg    <= cfg_data[LIM_W-1:0];
                    REG_RESIDUAL:      residual_reg      <= cfg_data[LIM_W-1:0];
                    REG_SCALE_ERROR:   scale_error_reg   <= signed'(cfg_data[SCALE_W-1:0]);
                    REG_POWER_COEFF:   power_coeff_reg   <= cfg_data[COEFF_W-1:0];
                    REG_FAULT_STUCK:   fault_stuck_reg   <= cfg_data[0];
                    REG_FAULT_DROPOUT: fault_dropout_reg <= cfg_data[0];
                    default:           ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        sum_reg  <= sum_next;
        if (state_reg == ST_BOUND)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (state_reg == ST_PLAY)
            box_reg <= box_next;
        if (accept)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                cmd_reg[i] <= zero_cmd ? '0 : all_cmd[i];
            end
        end
        if (load_res)
            res_item_reg <= res_item_next;
    end

endmodule
